>>> sv/oal_pkg.sv
package oal_pkg;

   // List geometry
   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int COUNT_W = 5;
   localparam int POS_W   = 5;
   localparam int FOUND_W = 4;
   localparam int VAL_W   = 32;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   typedef enum logic [1:0] {
      ACT_GET    = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_SEARCH = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef struct packed {
      action_type         action;
      logic [POS_W-1:0]   position;
      logic [VAL_W-1:0]   item_value;
   } req_type;

   typedef struct packed {
      status_type           status;
      logic [VAL_W-1:0]     read_value;
      logic [FOUND_W-1:0]   found_position;
      logic [COUNT_W-1:0]   entry_count;
   } rsp_type;

endpackage

>>> sv/oal_core.sv
module oal_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  oal_pkg::req_type req,
   input  logic             out_free,
   output logic             rsp_valid,
   output oal_pkg::rsp_type rsp
);
   import oal_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_GET_WAIT,
      S_INS_STEP,
      S_INS_MOVE,
      S_REM_STEP,
      S_REM_MOVE,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [VAL_W-1:0]     val_ff, val_in;
   logic [COUNT_W-1:0]   k_ff, k_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   status_type           status_ff, status_in;
   logic [VAL_W-1:0]     read_ff, read_in;
   logic [FOUND_W-1:0]   found_ff, found_in;

   // List store with one read and one write port, registered read
   logic [VAL_W-1:0]     mem [DEPTH];
   logic [VAL_W-1:0]     rd_data_ff;
   logic [IDX_W-1:0]     mem_ra;
   logic [IDX_W-1:0]     mem_wa;
   logic [VAL_W-1:0]     mem_wd;
   logic                 mem_we;

   logic [COUNT_W-1:0]   k_dec;
   logic [COUNT_W-1:0]   k_inc;

   assign k_dec = k_ff - COUNT_W'(1);
   assign k_inc = k_ff + COUNT_W'(1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      k_in      = k_ff;
      count_in  = count_ff;
      status_in = status_ff;
      read_in   = read_ff;
      found_in  = found_ff;
      mem_ra    = k_ff[IDX_W-1:0];
      mem_wa    = k_ff[IDX_W-1:0];
      mem_wd    = rd_data_ff;
      mem_we    = 1'b0;
      rsp_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in    = req.position;
               val_in    = req.item_value;
               status_in = ST_OK;
               read_in   = '0;
               found_in  = '0;
               unique case (req.action)
                  ACT_GET: begin
                     if (req.position >= count_ff) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        mem_ra   = req.position[IDX_W-1:0];
                        state_in = S_GET_WAIT;
                     end
                  end
                  ACT_INSERT: begin
                     if (req.position > count_ff) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else if (count_ff == FULL_COUNT) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        k_in     = count_ff;
                        state_in = S_INS_STEP;
                     end
                  end
                  ACT_REMOVE: begin
                     if (req.position >= count_ff) begin
                        status_in = ST_RANGE;
                        state_in  = S_DONE;
                     end else begin
                        k_in     = req.position;
                        state_in = S_REM_STEP;
                     end
                  end
                  ACT_SEARCH: begin
                     k_in     = '0;
                     state_in = S_SRCH_RD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_GET_WAIT: begin
            read_in  = rd_data_ff;
            state_in = S_DONE;
         end
         S_INS_STEP: begin
            if (k_ff > pos_ff) begin
               mem_ra   = k_dec[IDX_W-1:0];
               state_in = S_INS_MOVE;
            end else begin
               mem_we   = 1'b1;
               mem_wa   = pos_ff[IDX_W-1:0];
               mem_wd   = val_ff;
               count_in = count_ff + COUNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_INS_MOVE: begin
            mem_we   = 1'b1;
            k_in     = k_dec;
            state_in = S_INS_STEP;
         end
         S_REM_STEP: begin
            if (k_inc < count_ff) begin
               mem_ra   = k_inc[IDX_W-1:0];
               state_in = S_REM_MOVE;
            end else begin
               count_in = count_ff - COUNT_W'(1);
               state_in = S_DONE;
            end
         end
         S_REM_MOVE: begin
            mem_we   = 1'b1;
            k_in     = k_inc;
            state_in = S_REM_STEP;
         end
         S_SRCH_RD: begin
            if (k_ff < count_ff) begin
               state_in = S_SRCH_CMP;
            end else begin
               status_in = ST_MISSING;
               state_in  = S_DONE;
            end
         end
         S_SRCH_CMP: begin
            if (rd_data_ff == val_ff) begin
               found_in = k_ff[FOUND_W-1:0];
               state_in = S_DONE;
            end else begin
               k_in     = k_inc;
               state_in = S_SRCH_RD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      k_ff      <= k_in;
      status_ff <= status_in;
      read_ff   <= read_in;
      found_ff  <= found_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp.status         = status_ff;
   assign rsp.read_value     = read_ff;
   assign rsp.found_position = found_ff;
   assign rsp.entry_count    = count_ff;

endmodule

>>> sv/ordered_array_list_unit.sv
// Ordered list of up to 16 signed 32-bit entries with an entry count. Each request
// transaction carries get, insert, remove or search; one response transaction follows
// per request and always reports the count after the request. Requests are taken one
// at a time: req_tready is high only while the sequencer is idle. A list store with one
// read and one write port and a registered read is the one shared unit, so each entry
// moved passes through a read step and a write step, and each entry compared through a
// read step and a compare step. An insert shifts the entries from the position up one
// place, a remove shifts those above the position down one, and a search stops at the
// lowest matching index. Every request ends in a done state that hands the result to
// the response register before the return to idle. The response sits in an output
// register, so the next request is accepted while it waits for rsp_tready; while that
// register is still full, the sequencer holds its finished result and takes
// nothing new.
// Entries are not cleared at reset; only entries below the count are ever read back.
module ordered_array_list_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[4:0], item_value[36:5], zero fill
   input  logic [1:0]  req_tuser,   // action[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // read_value[31:0], found_position[35:32],
                                    // entry_count[40:36], zero fill
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import oal_pkg::*;

   req_type core_req;
   rsp_type core_rsp;
   logic    core_rsp_valid;
   logic    out_free;

   // Output register: holds one finished response transaction
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   assign core_req.action     = action_type'(req_tuser);
   assign core_req.position   = req_tdata[POS_W-1:0];
   assign core_req.item_value = req_tdata[POS_W +: VAL_W];

   // Slot is free if empty or being emptied this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   oal_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (core_req),
      .out_free  (out_free),
      .rsp_valid (core_rsp_valid),
      .rsp       (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (core_rsp_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {7'b0, rsp_data_ff.entry_count, rsp_data_ff.found_position,
                        rsp_data_ff.read_value};

endmodule

>>> sim/tb_ordered_array_list_unit.sv
`timescale 1ns / 1ps

// Self-checking bench for the ordered array list unit.
// A scoreboard class keeps its own copy of the list and its count, works out the
// response for every accepted request transaction and checks each response
// transaction against the oldest one waiting. Plain tasks drive the request side;
// a separate process drives rsp_tready with random stalls and one long hold-off.
module tb_ordered_array_list_unit;
   import oal_pkg::*;

   // Scoreboard: list shadow plus queue of predicted responses
   class list_scoreboard;
      logic [VAL_W-1:0]   entries [DEPTH];
      logic [COUNT_W-1:0] used;
      rsp_type            pending_responses [$];
      int                 mismatches;

      function new();
         used       = '0;
         mismatches = 0;
      endfunction

      // Applies one request to the shadow list and returns the response it causes
      function rsp_type predict_response(req_type r);
         rsp_type rsp;
         bit      hit;
         rsp = '{status: ST_OK, read_value: '0, found_position: '0, entry_count: '0};
         hit = 1'b0;
         case (r.action)
            ACT_GET: begin
               if (r.position >= used) rsp.status = ST_RANGE;
               else rsp.read_value = entries[r.position];
            end
            ACT_INSERT: begin
               // range check takes priority over the full check
               if (r.position > used) rsp.status = ST_RANGE;
               else if (used == FULL_COUNT) rsp.status = ST_FULL;
               else begin
                  for (int k = used; k > r.position; k--) entries[k] = entries[k-1];
                  entries[r.position] = r.item_value;
                  used++;
               end
            end
            ACT_REMOVE: begin
               if (r.position >= used) rsp.status = ST_RANGE;
               else begin
                  for (int k = r.position; k + 1 < used; k++) entries[k] = entries[k+1];
                  used--;
               end
            end
            default: begin
               // lowest matching index wins
               for (int k = 0; k < used; k++) begin
                  if (!hit && entries[k] == r.item_value) begin
                     hit = 1'b1;
                     rsp.found_position = FOUND_W'(k);
                  end
               end
               if (!hit) rsp.status = ST_MISSING;
            end
         endcase
         rsp.entry_count = used;
         return rsp;
      endfunction

      function void note_request(req_type r);
         pending_responses.push_back(predict_response(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response transaction: status %0d value %h count %0d",
                        got.status, got.read_value, got.entry_count);
            return;
         end
         want = pending_responses.pop_front();
         if (got.status !== want.status || got.read_value !== want.read_value ||
             got.found_position !== want.found_position ||
             got.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: status %0d/%0d value %h/%h found %0d/%0d count %0d/%0d",
                        want.status, got.status, want.read_value, got.read_value,
                        want.found_position, got.found_position,
                        want.entry_count, got.entry_count);
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;     // position[4:0], item_value[36:5], zero fill
   logic [1:0]  req_tuser  = '0;     // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;           // read_value[31:0], found_position[35:32],
                                     // entry_count[40:36], zero fill
   logic [1:0]  rsp_tuser;           // status[1:0]

   list_scoreboard board = new();
   int             requests_taken = 0;
   bit             no_idling = 1'b0;   // set for a stretch with no gaps on either side

   ordered_array_list_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_request('{action: action_type'(req_tuser), position: req_tdata[4:0],
                                 item_value: req_tdata[36:5]});
            requests_taken++;
         end
         if (rsp_tvalid && rsp_tready)
            board.check_response('{status: status_type'(rsp_tuser),
                                   read_value: rsp_tdata[31:0],
                                   found_position: rsp_tdata[35:32],
                                   entry_count: rsp_tdata[40:36]});
      end
   end

   // Receiver: random stalls, plus one long hold-off so the output register fills
   // and the unit stops taking requests while the sender keeps offering
   initial begin
      int hold_cycles;
      bit hold_done;
      hold_cycles = 0;
      hold_done   = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && requests_taken >= 500) begin
            hold_done   = 1'b1;
            hold_cycles = 300;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idling || ($urandom_range(99) >= 16);
         end
      end
   end

   // One request transaction: random gap, then hold until accepted
   task automatic send_request(input action_type act, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
      @(negedge clock);
      while (!no_idling && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {3'b000, val, pos};
      do @(posedge clock); while (!req_tready);
   endtask

   // Sender goes quiet until every predicted response has come back
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending_responses.size() != 0) @(posedge clock);
   endtask

   // Random request biased by a fill/drain phase so the count sweeps empty to full
   task automatic send_random_request(input bit filling);
      action_type         act;
      logic [POS_W-1:0]   pos;
      logic [VAL_W-1:0]   val;
      int                 pick;
      int                 cnt;
      cnt  = board.used;
      pick = $urandom_range(99);
      if (filling)
         act = pick < 45 ? ACT_INSERT : pick < 60 ? ACT_REMOVE : pick < 80 ? ACT_GET : ACT_SEARCH;
      else
         act = pick < 45 ? ACT_REMOVE : pick < 60 ? ACT_INSERT : pick < 80 ? ACT_GET : ACT_SEARCH;

      // mostly in range, some anywhere in the 5-bit field
      if ($urandom_range(99) < 15) pos = POS_W'($urandom_range(31));
      else if (act == ACT_INSERT) pos = POS_W'($urandom_range(cnt));
      else pos = POS_W'(cnt > 0 ? $urandom_range(cnt - 1) : 0);

      // values already in the list give search hits and duplicates
      pick = $urandom_range(99);
      if (pick < 35 && cnt > 0) val = board.entries[$urandom_range(cnt - 1)];
      else if (pick < 60) begin
         case ($urandom_range(4))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'hFFFF_FFFF;
            3: val = 32'h0000_0000;
            default: val = VAL_W'($urandom_range(7));
         endcase
      end else val = $urandom;
      send_request(act, pos, val);
   endtask

   initial begin
      bit filling;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty-list rejections
      send_request(ACT_GET,    5'd0, 32'h0000_0000);
      send_request(ACT_REMOVE, 5'd0, 32'hFFFF_FFFF);
      send_request(ACT_SEARCH, 5'd0, 32'h0000_0000);
      send_request(ACT_INSERT, 5'd1, 32'h1111_1111);   // beyond the count
      // front, end and middle inserts with extreme values
      send_request(ACT_INSERT, 5'd0, 32'h8000_0000);
      send_request(ACT_INSERT, 5'd1, 32'h7FFF_FFFF);
      send_request(ACT_INSERT, 5'd1, 32'h0000_0000);
      // fill to capacity, alternating front and tail, with a duplicate of the max
      for (int k = 3; k < DEPTH; k++)
         send_request(ACT_INSERT, (k % 2) ? 5'd0 : POS_W'(k),
                      k == 9 ? 32'h7FFF_FFFF : k == 11 ? 32'hFFFF_FFFF : $urandom);
      send_request(ACT_INSERT, 5'd16, 32'h0000_1234);  // full list
      send_request(ACT_INSERT, 5'd31, 32'h0000_1234);  // range beats full
      send_request(ACT_GET,    5'd15, 32'hFFFF_FFFF);
      send_request(ACT_SEARCH, 5'd31, 32'h7FFF_FFFF);  // first of two matches
      send_request(ACT_REMOVE, 5'd15, 32'h0000_0000);
      drain_responses();

      // Random part
      filling = 1'b1;
      for (int n = 0; n < 1825; n++) begin
         no_idling = (n >= 1200 && n < 1500);
         if (n == 1000) drain_responses();
         if (board.used == FULL_COUNT && $urandom_range(99) < 30) filling = 1'b0;
         else if (board.used == 0) filling = 1'b1;
         send_random_request(filling);
      end

      drain_responses();
      repeat (40) @(posedge clock);
      if (board.mismatches == 0 && board.pending_responses.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
